### design/irpw_pkg.sv
// Shared types, constants and the LED lookup for the infrared frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package irpw_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CHANGE_W = 4;
    localparam int BITS_W   = 6;

    localparam logic [SAMPLE_W-1:0] WINDOW_RESET = 10'd1000;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 10'd75;
    localparam logic [CHANGE_W-1:0] MAX_CHANGES  = 4'd11;
    localparam logic [2:0]          FIRST_POS    = 3'd5;
    localparam logic [1:0]          ADDR_OK      = 2'b11;

    typedef enum logic
    {
        CFG_WINDOW_SAMPLES = 1'b0,
        CFG_LONG_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_t;

    localparam logic [2:0] LED_RED     = 3'd1;
    localparam logic [2:0] LED_BLUE    = 3'd2;
    localparam logic [2:0] LED_PINK    = 3'd3;
    localparam logic [2:0] LED_GREEN   = 3'd4;
    localparam logic [2:0] LED_YELLOW  = 3'd5;
    localparam logic [2:0] LED_SKYBLUE = 3'd6;
    localparam logic [2:0] LED_WHITE   = 3'd7;

    localparam logic [3:0] CMD_RED     = 4'd0;
    localparam logic [3:0] CMD_BLUE    = 4'd1;
    localparam logic [3:0] CMD_GREEN   = 4'd2;
    localparam logic [3:0] CMD_YELLOW  = 4'd3;
    localparam logic [3:0] CMD_SKYBLUE = 4'd4;

    typedef struct packed
    {
        logic valid;
        logic level;
    } sample_t;

    typedef struct packed
    {
        status_t           status;
        logic [2:0]        led_rgb;
        logic [3:0]        command;
        logic [BITS_W-1:0] frame_bits;
    } result_t;

    function automatic result_t build_result(input logic [BITS_W-1:0] bits);
        result_t r;
        r.frame_bits = bits;
        r.command    = bits[3:0];
        r.status     = ST_OK;
        r.led_rgb    = LED_PINK;
        if (bits[5:4] != ADDR_OK)
        begin
            r.status  = ST_BAD_ADDR;
            r.led_rgb = LED_WHITE;
        end
        else
        begin
            case (bits[3:0])
                CMD_RED:     r.led_rgb = LED_RED;
                CMD_BLUE:    r.led_rgb = LED_BLUE;
                CMD_GREEN:   r.led_rgb = LED_GREEN;
                CMD_YELLOW:  r.led_rgb = LED_YELLOW;
                CMD_SKYBLUE: r.led_rgb = LED_SKYBLUE;
                default:
                begin
                    r.status  = ST_UNKNOWN;
                    r.led_rgb = LED_PINK;
                end
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/irpw_sample_reg.sv
// Input register stage holding one accepted receiver sample.
`timescale 1ns / 1ps
`default_nettype none
module irpw_sample_reg
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic            in_valid,
    input  wire logic            ir_level,
    output irpw_pkg::sample_t    sample
);
    import irpw_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic level_reg;

    assign valid_next = take ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            level_reg <= ir_level;
        end
    end

    assign sample = {valid_reg, level_reg};

endmodule
`default_nettype wire

### design/irpw_decode.sv
// Window tracking, run measurement and bit decoding for one sample per cycle while advance is high.
`timescale 1ns / 1ps
`default_nettype none
module irpw_decode
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire irpw_pkg::sample_t              sample,
    input  wire logic                           advance,
    input  wire logic [irpw_pkg::SAMPLE_W-1:0]  window_samples,
    input  wire logic [irpw_pkg::SAMPLE_W-1:0]  long_threshold,
    output logic                                fire,
    output irpw_pkg::result_t                   result
);
    import irpw_pkg::*;

    logic                previous_level_reg;
    logic                previous_level_next;
    logic                capturing_reg;
    logic                capturing_next;
    logic [SAMPLE_W-1:0] sample_index_reg;
    logic [SAMPLE_W-1:0] sample_index_next;
    logic [CHANGE_W-1:0] change_count_reg;
    logic [CHANGE_W-1:0] change_count_next;
    logic [SAMPLE_W-1:0] last_change_reg;
    logic [SAMPLE_W-1:0] last_change_next;
    logic [BITS_W-1:0]   decoded_bits_reg;
    logic [BITS_W-1:0]   decoded_bits_next;
    logic [SAMPLE_W-1:0] run_length;
    logic [2:0]          bit_pos;
    logic [SAMPLE_W:0]   index_plus_one;

    always_comb
    begin
        previous_level_next = sample.level;
        capturing_next      = capturing_reg;
        sample_index_next   = sample_index_reg;
        change_count_next   = change_count_reg;
        last_change_next    = last_change_reg;
        decoded_bits_next   = decoded_bits_reg;
        run_length          = '0;
        bit_pos             = FIRST_POS - {1'b0, change_count_reg[2:1]};
        if (change_count_reg[3])
        begin
            bit_pos = FIRST_POS - 3'd4 - {2'b00, change_count_reg[1]};
        end

        if (!capturing_reg)
        begin
            if (previous_level_reg && !sample.level)
            begin
                capturing_next    = 1'b1;
                sample_index_next = '0;
                change_count_next = '0;
                last_change_next  = '0;
                decoded_bits_next = '0;
            end
        end
        else
        begin
            sample_index_next = sample_index_reg + 1'b1;
            if ((sample.level != previous_level_reg) && (change_count_reg < MAX_CHANGES))
            begin
                run_length = sample_index_next - last_change_reg;
                if (!change_count_reg[0] && (run_length > long_threshold))
                begin
                    decoded_bits_next[bit_pos] = 1'b1;
                end
                last_change_next  = sample_index_next;
                change_count_next = change_count_reg + 1'b1;
            end
        end

        index_plus_one = {1'b0, sample_index_next} + 1'b1;
        fire = sample.valid && capturing_next &&
               (index_plus_one >= {1'b0, window_samples});
        if (fire)
        begin
            capturing_next = 1'b0;
        end
        result = build_result(decoded_bits_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= 1'b1;
            capturing_reg      <= 1'b0;
            sample_index_reg   <= '0;
            change_count_reg   <= '0;
            last_change_reg    <= '0;
            decoded_bits_reg   <= '0;
        end
        else if (advance)
        begin
            previous_level_reg <= previous_level_next;
            capturing_reg      <= capturing_next;
            sample_index_reg   <= sample_index_next;
            change_count_reg   <= change_count_next;
            last_change_reg    <= last_change_next;
            decoded_bits_reg   <= decoded_bits_next;
        end
    end

endmodule
`default_nettype wire

### design/irpw_result_reg.sv
// Output register holding one finished frame result until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module irpw_result_reg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire irpw_pkg::result_t result_in,
    input  wire logic          out_stall,
    output logic               out_valid,
    output irpw_pkg::result_t  result_out
);
    import irpw_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule
`default_nettype wire

### design/ir_pulse_width_frame_decoder_core.sv
// Top level of the infrared pulse-width frame decoder.
//
// The input channel takes one receiver sample per request (ir_level) under
// in_valid and in_stall. While idle, a high sample followed by a low sample
// opens a capture window; the block measures the runs between level changes
// and, at the window's last sample, delivers one result request carrying
// status, led_rgb, command and frame_bits under out_valid and out_stall.
// Samples that do not end a window give no result.
// An accepted sample is held in the input register and decoded from there; a
// window's last sample loads its result into the output register once that
// register can accept it, which raises out_valid.
// One sample is taken every cycle bar the output stall below; the decode
// path (one subtract, one compare and counter updates) sets that figure.
// When the receiver stalls, samples that end no window still flow in; the
// input stalls only when a second result is ready while the first waits.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes window_samples or long_threshold; it is always ready.
// Reset clears the window state, marks the line idle high and restores the
// register defaults of 1000 samples and a threshold of 75.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_width_frame_decoder_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           ir_level,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    output logic [2:0]                          led_rgb,
    output logic [3:0]                          command,
    output logic [irpw_pkg::BITS_W-1:0]         frame_bits,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [irpw_pkg::SAMPLE_W-1:0]  cfg_data
);
    import irpw_pkg::*;

    logic [SAMPLE_W-1:0] window_samples_reg;
    logic [SAMPLE_W-1:0] long_threshold_reg;
    sample_t             sample;
    result_t             dec_result;
    result_t             out_result;
    logic                fire;
    logic                advance;
    logic                take;
    logic                out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_samples_reg <= WINDOW_RESET;
            long_threshold_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_SAMPLES: window_samples_reg <= cfg_data;
                CFG_LONG_THRESHOLD: long_threshold_reg <= cfg_data;
                default:            window_samples_reg <= window_samples_reg;
            endcase
        end
    end

    assign out_free = !out_valid || !out_stall;
    assign advance  = sample.valid && (!fire || out_free);
    assign take     = !sample.valid || advance;
    assign in_stall = !take;

    irpw_sample_reg u_sample
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_valid (in_valid),
        .ir_level (ir_level),
        .sample   (sample)
    );

    irpw_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .advance        (advance),
        .window_samples (window_samples_reg),
        .long_threshold (long_threshold_reg),
        .fire           (fire),
        .result         (dec_result)
    );

    irpw_result_reg u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && fire),
        .result_in  (dec_result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign status     = out_result.status;
    assign led_rgb    = out_result.led_rgb;
    assign command    = out_result.command;
    assign frame_bits = out_result.frame_bits;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output register could accept");

    a_address_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((frame_bits[5:4] == ADDR_OK) == (status != ST_BAD_ADDR)))
        else $error("status disagrees with the address bits");

    a_command_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command == frame_bits[3:0]))
        else $error("command differs from the low frame bits");
`endif

endmodule
`default_nettype wire

### tb/tb_ir_pulse_width_frame_decoder_core.sv
// Testbench that drives the infrared frame decoder with pulse trains and checks each decoded frame.
`timescale 1ns / 1ps

import irpw_pkg::*;

class ir_frame_scoreboard;

    logic [SAMPLE_W-1:0] window_len;
    logic [SAMPLE_W-1:0] threshold;
    logic                prev_level;
    logic                capturing;
    logic [SAMPLE_W-1:0] sample_idx;
    logic [CHANGE_W-1:0] change_cnt;
    logic [SAMPLE_W-1:0] last_change;
    logic [BITS_W-1:0]   bits;
    result_t             pending_frames[$];
    int unsigned         busy_samples;
    int unsigned         frames_predicted;
    int unsigned         errors;

    function new();
        window_len       = WINDOW_RESET;
        threshold        = THRESH_RESET;
        prev_level       = 1'b1;
        capturing        = 1'b0;
        sample_idx       = '0;
        change_cnt       = '0;
        last_change      = '0;
        bits             = '0;
        busy_samples     = 0;
        frames_predicted = 0;
        errors           = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [SAMPLE_W-1:0] val);
        if (idx == CFG_WINDOW_SAMPLES)
            window_len = val;
        else
            threshold = val;
    endfunction

    function result_t frame_result(logic [BITS_W-1:0] fb);
        result_t r;
        r.frame_bits = fb;
        r.command    = fb[3:0];
        r.status     = ST_OK;
        if (fb[5:4] != ADDR_OK)
        begin
            r.status  = ST_BAD_ADDR;
            r.led_rgb = LED_WHITE;
        end
        else if (fb[3:0] == CMD_RED)
            r.led_rgb = LED_RED;
        else if (fb[3:0] == CMD_BLUE)
            r.led_rgb = LED_BLUE;
        else if (fb[3:0] == CMD_GREEN)
            r.led_rgb = LED_GREEN;
        else if (fb[3:0] == CMD_YELLOW)
            r.led_rgb = LED_YELLOW;
        else if (fb[3:0] == CMD_SKYBLUE)
            r.led_rgb = LED_SKYBLUE;
        else
        begin
            r.status  = ST_UNKNOWN;
            r.led_rgb = LED_PINK;
        end
        return r;
    endfunction

    function void note_sample(logic lvl);
        logic [SAMPLE_W-1:0] run_len;
        logic [2:0]          pos;
        if (!capturing)
        begin
            if (prev_level && !lvl)
            begin
                capturing   = 1'b1;
                sample_idx  = '0;
                change_cnt  = '0;
                last_change = '0;
                bits        = '0;
            end
        end
        else
        begin
            sample_idx = sample_idx + 10'd1;
            if (lvl != prev_level && change_cnt < MAX_CHANGES)
            begin
                run_len = sample_idx - last_change;
                if (!change_cnt[0] && run_len > threshold)
                begin
                    pos       = FIRST_POS - 3'(change_cnt[3:1]);
                    bits[pos] = 1'b1;
                end
                last_change = sample_idx;
                change_cnt  = change_cnt + 4'd1;
            end
        end
        prev_level = lvl;
        if (capturing)
        begin
            busy_samples++;
            if ({1'b0, sample_idx} + 11'd1 >= {1'b0, window_len})
            begin
                pending_frames.push_back(frame_result(bits));
                frames_predicted++;
                capturing = 1'b0;
            end
        end
    endfunction

    function void check_result(logic [1:0] st, logic [2:0] led, logic [3:0] cmd,
                               logic [BITS_W-1:0] fb);
        result_t want;
        if (pending_frames.size() == 0)
        begin
            $display("%0t: unexpected frame, expected none, got status %0d led %0d cmd %0d bits %b",
                     $time, st, led, cmd, fb);
            errors++;
            return;
        end
        want = pending_frames.pop_front();
        if (st !== want.status)
        begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, st);
            errors++;
        end
        if (led !== want.led_rgb)
        begin
            $display("%0t: led_rgb expected %0d, got %0d", $time, want.led_rgb, led);
            errors++;
        end
        if (cmd !== want.command)
        begin
            $display("%0t: command expected %0d, got %0d", $time, want.command, cmd);
            errors++;
        end
        if (fb !== want.frame_bits)
        begin
            $display("%0t: frame_bits expected %b, got %b", $time, want.frame_bits, fb);
            errors++;
        end
    endfunction

endclass

module tb_ir_pulse_width_frame_decoder_core;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_SAMPLES = 400;
    localparam int RANDOM_FRAMES  = 6;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                ir_level   = 1'b1;
    logic                out_stall  = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_index  = 1'b0;
    logic [SAMPLE_W-1:0] cfg_data   = '0;
    logic                in_stall;
    logic                out_valid;
    logic [1:0]          status;
    logic [2:0]          led_rgb;
    logic [3:0]          command;
    logic [BITS_W-1:0]   frame_bits;
    logic                cfg_ready;

    ir_frame_scoreboard  sb = new();
    int unsigned         tx_idle_pct  = 20;
    int unsigned         rx_stall_pct = 20;
    int unsigned         rx_hold      = 0;
    int unsigned         quiet_cycles = 0;

    ir_pulse_width_frame_decoder_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ir_level   (ir_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .led_rgb    (led_rgb),
        .command    (command),
        .frame_bits (frame_bits),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [BITS_W-1:0] random_pattern();
        logic [BITS_W-1:0] p;
        p = BITS_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            p[5:4] = ADDR_OK;
        if ($urandom_range(0, 9) < 6)
            p[3:0] = 4'($urandom_range(CMD_RED, CMD_SKYBLUE));
        return p;
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold != 0)
            rx_hold--;
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            out_stall <= 1'b1;
            rx_hold = pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
            rx_hold = $urandom_range(0, 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, led_rgb, command, frame_bits);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic lvl);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ir_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(lvl);
    endtask

    task automatic send_run(input logic lvl, input int unsigned len);
        repeat (len) send_sample(lvl);
    endtask

    // Low runs carry the bits; the high runs between them are padding of any length.
    task automatic send_frame(input logic [BITS_W-1:0] pattern, input int unsigned low_runs);
        int unsigned thr;
        thr = sb.threshold;
        send_run(1'b1, $urandom_range(1, 3));
        for (int k = 0; k < low_runs; k++)
        begin
            if (pattern[5 - k])
                send_run(1'b0, $urandom_range(thr + 1, thr + 4));
            else
                send_run(1'b0, (thr == 0) ? 1 : $urandom_range(1, thr));
            if (k < 5)
                send_run(1'b1, $urandom_range(1, 4));
        end
    endtask

    task automatic extra_toggles(input int unsigned n);
        repeat (n)
        begin
            send_run(1'b0, $urandom_range(1, 3));
            send_run(1'b1, $urandom_range(1, 3));
        end
    endtask

    task automatic close_window(input logic lvl);
        while (sb.capturing)
            send_sample(lvl);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [SAMPLE_W-1:0] window, input logic [SAMPLE_W-1:0] thresh);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_SAMPLES;
        cfg_data  <= window;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(CFG_WINDOW_SAMPLES, window);
        cfg_index <= CFG_LONG_THRESHOLD;
        cfg_data  <= thresh;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(CFG_LONG_THRESHOLD, thresh);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned base_samples;
        int unsigned base_frames;
        int unsigned pick;
        int unsigned win;
        int unsigned thr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The line is taken as high out of reset, so an opening low starts a window at once.
        // Runs just above the default threshold and one equal to it decode as 1, 1 and 0.
        send_run(1'b0, 76);
        send_run(1'b1, 2);
        send_run(1'b0, 80);
        send_run(1'b1, 2);
        send_run(1'b0, 75);
        send_run(1'b1, 1);
        drain();
        configure(10'd250, 10'd75);
        close_window(1'b1);
        drain();

        configure(10'd52, 10'd1);
        for (int c = CMD_RED; c <= CMD_SKYBLUE; c++)
        begin
            send_frame({ADDR_OK, 4'(c)}, 6);
            close_window(1'b1);
        end
        send_frame({ADDR_OK, CMD_SKYBLUE + 4'd1}, 6);
        close_window(1'b1);
        send_frame(6'b111111, 6);
        close_window(1'b1);
        send_frame(6'b001111, 6);
        close_window(1'b1);
        send_frame(6'b100010, 6);
        close_window(1'b1);
        send_frame(6'b000000, 6);
        close_window(1'b1);
        send_frame(6'b111111, 2);
        close_window(1'b1);
        send_frame({ADDR_OK, CMD_GREEN}, 6);
        extra_toggles(4);
        close_window(1'b1);
        send_frame({ADDR_OK, CMD_BLUE}, 6);
        close_window(1'b0);
        send_run(1'b0, 8);
        send_frame({ADDR_OK, CMD_YELLOW}, 6);
        close_window(1'b1);
        drain();

        configure(10'd0, 10'd3);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        drain();
        configure(10'd1, 10'd3);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        drain();

        // Shrink the window under an open capture; it must end at the next sample.
        configure(10'd400, 10'd3);
        send_frame({ADDR_OK, CMD_YELLOW}, 6);
        drain();
        configure(10'd10, 10'd3);
        close_window(1'b1);
        drain();

        configure(10'd52, 10'd0);
        send_frame(random_pattern(), 6);
        close_window(1'b1);
        drain();

        base_samples = sb.busy_samples;
        base_frames  = sb.frames_predicted;
        while (sb.busy_samples - base_samples < RANDOM_SAMPLES ||
               sb.frames_predicted - base_frames < RANDOM_FRAMES)
        begin
            pick = $urandom_range(0, 2);
            tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            pick = $urandom_range(0, 2);
            rx_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                win = $urandom_range(2, 12);
            else if (pick == 1)
                win = $urandom_range(100, 160);
            else
                win = $urandom_range(40, 80);
            thr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            configure(SAMPLE_W'(win), SAMPLE_W'(thr));
            repeat ($urandom_range(2, 4))
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    send_frame(random_pattern(), 6);
                else if (pick < 16)
                    send_frame(random_pattern(), $urandom_range(1, 5));
                else if (pick < 18)
                begin
                    send_frame(random_pattern(), 6);
                    extra_toggles($urandom_range(1, 4));
                end
                else
                    repeat ($urandom_range(5, 40)) send_sample(1'($urandom));
                if ($urandom_range(0, 3) == 0)
                    close_window(1'b0);
                close_window(1'b1);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
design/irpw_pkg.sv
design/irpw_sample_reg.sv
design/irpw_decode.sv
design/irpw_result_reg.sv
design/ir_pulse_width_frame_decoder_core.sv
tb/tb_ir_pulse_width_frame_decoder_core.sv
